// ===== rtl/sitdr_pkg.sv =====
// Shared types and constants for the signed-integer display register writer.
package sitdr_pkg;

    // Display driver register map and glyph codes
    localparam logic [7:0] DECODE_REG_ADDR = 8'd9;
    localparam logic [7:0] MINUS_GLYPH     = 8'd10;
    localparam logic [7:0] CODE_B_MODE     = 8'hFF;
    localparam logic [3:0] MAX_POSITION    = 4'd8;

    // Width of the input value and of its decimal form
    localparam int VALUE_W   = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W     = 4 * NUM_DIGITS;

    // One classified number as it waits between front and back
    typedef struct packed {
        logic [3:0]         pos;
        logic               negative;
        logic [VALUE_W-1:0] mag;
    } sitdr_item_t;

endpackage

// ===== rtl/signed_int_to_digit_register_writes.sv =====
// Top level of the signed-integer display register writer.
// Each accepted number becomes a run of display-driver register writes: decode
// mode to code-B, a minus glyph for negative values when a position is left,
// the decimal digits most significant first at positions counting down (digits
// past position 0 are dropped), and a closing write of the configured decode
// mode that carries the leftover position and has last set. A number leaves
// the queue, passes through the shift-add-3 converter (four bits per cycle),
// and then the single write sequencer sends its writes in order, each one held
// while the output is stalled, with a DIGIT step that writes nothing when the
// positions run out before the digits do or no position is left after the
// open or minus write. Up to QUEUE_DEPTH numbers wait ahead of the sequencer.
// The decode-mode register is always ready and resets to 0xFF.
module signed_int_to_digit_register_writes #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [3:0]          start_position,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          reg_address,
    output logic [7:0]          reg_data,
    output logic [3:0]          next_position,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          decode_mode_restore
);
    import sitdr_pkg::*;

    logic        cfg_write;
    logic [7:0]  restore_mode_reg, restore_mode_next;
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_not_empty;
    sitdr_item_t push_item;
    sitdr_item_t pop_item;

    // Configuration register: always ready
    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign restore_mode_next = cfg_write ? decode_mode_restore : restore_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_mode_reg <= CODE_B_MODE;
        end
        else
        begin
            restore_mode_reg <= restore_mode_next;
        end
    end

    sitdr_front u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_position (start_position),
        .value          (value),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    sitdr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .not_empty (q_not_empty)
    );

    sitdr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .restore_mode  (restore_mode_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reg_address   (reg_address),
        .reg_data      (reg_data),
        .next_position (next_position),
        .last          (last)
    );

endmodule

// ===== rtl/sitdr_front.sv =====
// Front end: takes input transfers, clamps the position and forms sign and magnitude.
module sitdr_front (
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [3:0]               start_position,
    input  logic signed [31:0]       value,
    input  logic                     q_full,
    output logic                     q_push,
    output sitdr_pkg::sitdr_item_t   q_item
);
    import sitdr_pkg::*;

    logic                negative;
    logic [VALUE_W-1:0]  raw;

    // Hold the producer while the queue has no room
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Classify: clamp position, split sign and magnitude
    assign raw      = VALUE_W'(value);
    assign negative = raw[VALUE_W-1];

    always_comb
    begin
        q_item.pos      = (start_position > MAX_POSITION) ? MAX_POSITION : start_position;
        q_item.negative = negative;
        q_item.mag      = negative ? (VALUE_W'(0) - raw) : raw;
    end

endmodule

// ===== rtl/sitdr_queue.sv =====
// Small FIFO of classified numbers between the front end and the write sequencer.
module sitdr_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sitdr_pkg::sitdr_item_t push_item,
    output logic                   full,
    input  logic                   pop,
    output sitdr_pkg::sitdr_item_t pop_item,
    output logic                   not_empty
);
    import sitdr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sitdr_item_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    // Advance pointers and count on each transfer
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/sitdr_back.sv =====
// Back end: converts the magnitude to decimal and sequences the register writes.
module sitdr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_not_empty,
    input  sitdr_pkg::sitdr_item_t q_item,
    output logic                   q_pop,
    input  logic [7:0]             restore_mode,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             reg_address,
    output logic [7:0]             reg_data,
    output logic [3:0]             next_position,
    output logic                   last
);
    import sitdr_pkg::*;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_OPEN  = 3'd2;
    localparam logic [2:0] ST_MINUS = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;
    localparam logic [2:0] ST_CLOSE = 3'd5;

    // Shift-add-3 conversion, four bits per cycle
    localparam int BITS_PER_CYCLE = 4;
    localparam int CONV_CYCLES    = VALUE_W / BITS_PER_CYCLE;
    localparam int CNT_W          = $clog2(CONV_CYCLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CONV_CYCLES - 1);

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [3:0]         pos_reg, pos_next;
    logic               neg_reg, neg_next;
    logic [3:0]         dig_reg, dig_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         addr_reg, addr_next;
    logic [7:0]         data_reg, data_next;
    logic [3:0]         npos_reg, npos_next;
    logic               last_reg, last_next;

    logic               out_free;
    logic [VALUE_W-1:0] bin_step;
    logic [BCD_W-1:0]   bcd_step;
    logic [3:0]         msd;
    logic [3:0]         cur_digit;

    assign out_valid     = out_valid_reg;
    assign reg_address   = addr_reg;
    assign reg_data      = data_reg;
    assign next_position = npos_reg;
    assign last          = last_reg;

    // Output slot can take a new write when empty or being drained
    assign out_free  = !out_valid_reg || !out_stall;
    assign cur_digit = bcd_reg[{dig_reg, 2'b00} +: 4];

    // Four dependent shift-add-3 steps
    always_comb
    begin
        bin_step = bin_reg;
        bcd_step = bcd_reg;
        for (int s = 0; s < BITS_PER_CYCLE; s++)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                if (bcd_step[4*i +: 4] >= 4'd5)
                begin
                    bcd_step[4*i +: 4] = bcd_step[4*i +: 4] + 4'd3;
                end
            end
            bcd_step = {bcd_step[BCD_W-2:0], bin_step[VALUE_W-1]};
            bin_step = {bin_step[VALUE_W-2:0], 1'b0};
        end
    end

    // Find the most significant nonzero digit; zero shows one digit
    always_comb
    begin
        msd = 4'd0;
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                msd = 4'(i);
            end
        end
    end

    // Sequence: convert, open, optional minus, digits, close
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        dig_next       = dig_reg;
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        npos_next      = npos_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;

        // Drop the write once it is transferred
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    bin_next   = q_item.mag;
                    bcd_next   = '0;
                    pos_next   = q_item.pos;
                    neg_next   = q_item.negative;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bin_next = bin_step;
                bcd_next = bcd_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_OPEN;
                end
            end
            ST_OPEN:
            begin
                dig_next = msd;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    addr_next      = DECODE_REG_ADDR;
                    data_next      = CODE_B_MODE;
                    npos_next      = 4'd0;
                    last_next      = 1'b0;
                    state_next     = (neg_reg && pos_reg != 4'd0) ? ST_MINUS : ST_DIGIT;
                end
            end
            ST_MINUS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    addr_next      = {4'd0, pos_reg};
                    data_next      = MINUS_GLYPH;
                    npos_next      = 4'd0;
                    last_next      = 1'b0;
                    pos_next       = pos_reg - 4'd1;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (pos_reg == 4'd0)
                begin
                    state_next = ST_CLOSE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    addr_next      = {4'd0, pos_reg};
                    data_next      = {4'd0, cur_digit};
                    npos_next      = 4'd0;
                    last_next      = 1'b0;
                    pos_next       = pos_reg - 4'd1;
                    if (dig_reg == 4'd0)
                    begin
                        state_next = ST_CLOSE;
                    end
                    else
                    begin
                        dig_next = dig_reg - 4'd1;
                    end
                end
            end
            ST_CLOSE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    addr_next      = DECODE_REG_ADDR;
                    data_next      = restore_mode;
                    npos_next      = pos_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output payload
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        pos_reg  <= pos_next;
        neg_reg  <= neg_next;
        dig_reg  <= dig_next;
        addr_reg <= addr_next;
        data_reg <= data_next;
        npos_reg <= npos_next;
        last_reg <= last_next;
    end

endmodule

// ===== tb/display_write_monitor.sv =====
// Monitor that predicts and checks the register writes of the number display writer.
module display_write_monitor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [3:0]         start_position,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [7:0]         reg_address,
    input  logic [7:0]         reg_data,
    input  logic [3:0]         next_position,
    input  logic               last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [7:0]         decode_mode_restore,
    output int                 pending_writes,
    output int                 failures
);
    import sitdr_pkg::*;

    typedef struct packed {
        logic [7:0] address;
        logic [7:0] data;
        logic [3:0] pos_left;
        logic       is_last;
    } reg_write_t;

    reg_write_t upcoming_writes[$];
    logic [7:0] restore_mode;

    initial
    begin
        pending_writes = 0;
        failures = 0;
        restore_mode = CODE_B_MODE;
    end

    // Print one line per mismatch and count it
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        failures = failures + 1;
    endtask

    task automatic add_write(input logic [7:0] address, input logic [7:0] data,
                             input logic [3:0] pos_left, input logic is_last);
        reg_write_t w;
        w.address = address;
        w.data = data;
        w.pos_left = pos_left;
        w.is_last = is_last;
        upcoming_writes.push_back(w);
    endtask

    // Queue the whole run of writes that one number produces
    task automatic predict_register_writes(input logic [3:0] start, input logic [31:0] raw);
        logic [3:0]      pos;
        logic            negative;
        logic [31:0]     mag32;
        longint unsigned mag;
        longint unsigned scale;
        longint unsigned digit;
        int              ndig;
        int              d;
        pos = (start > MAX_POSITION) ? MAX_POSITION : start;
        negative = raw[31];
        mag32 = negative ? (32'd0 - raw) : raw;
        mag = mag32;
        add_write(DECODE_REG_ADDR, CODE_B_MODE, 4'd0, 1'b0);
        if (negative && pos != 4'd0)
        begin
            add_write({4'd0, pos}, MINUS_GLYPH, 4'd0, 1'b0);
            pos = pos - 4'd1;
        end
        // Count decimal digits; scale ends at ten to the power of (digits - 1)
        ndig = 1;
        scale = 10;
        while (ndig < NUM_DIGITS && mag >= scale)
        begin
            ndig = ndig + 1;
            scale = scale * 10;
        end
        scale = scale / 10;
        // Emit digits most significant first; drop them once no position is left
        for (d = ndig - 1; d >= 0; d--)
        begin
            digit = (mag / scale) % 10;
            if (pos != 4'd0)
            begin
                add_write({4'd0, pos}, digit[7:0], 4'd0, 1'b0);
                pos = pos - 4'd1;
            end
            scale = scale / 10;
        end
        add_write(DECODE_REG_ADDR, restore_mode, pos, 1'b1);
    endtask

    // Watch the three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        reg_write_t want;
        if (!rst_n)
        begin
            restore_mode = CODE_B_MODE;
            upcoming_writes.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                restore_mode = decode_mode_restore;
            if (in_valid && !in_stall)
                predict_register_writes(start_position, value);
            if (out_valid && !out_stall)
            begin
                if (upcoming_writes.size() == 0)
                begin
                    flag_mismatch("unexpected write, address", reg_address, 0);
                end
                else
                begin
                    want = upcoming_writes.pop_front();
                    if (reg_address !== want.address)
                        flag_mismatch("reg_address", reg_address, want.address);
                    if (reg_data !== want.data)
                        flag_mismatch("reg_data", reg_data, want.data);
                    if (next_position !== want.pos_left)
                        flag_mismatch("next_position", next_position, want.pos_left);
                    if (last !== want.is_last)
                        flag_mismatch("last", last, want.is_last);
                end
            end
        end
        pending_writes = upcoming_writes.size();
    end

endmodule

// ===== tb/signed_int_to_digit_register_writes_test.sv =====
// Stimulus and verdict for the signed-integer display register writer.
module signed_int_to_digit_register_writes_test;
    import sitdr_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 73;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [3:0]         start_position;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         reg_address;
    logic [7:0]         reg_data;
    logic [3:0]         next_position;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         decode_mode_restore;

    int pending_writes;
    int failures;
    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles;

    signed_int_to_digit_register_writes dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .start_position      (start_position),
        .value               (value),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .reg_address         (reg_address),
        .reg_data            (reg_data),
        .next_position       (next_position),
        .last                (last),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .decode_mode_restore (decode_mode_restore)
    );

    display_write_monitor monitor (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .start_position      (start_position),
        .value               (value),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .reg_address         (reg_address),
        .reg_data            (reg_data),
        .next_position       (next_position),
        .last                (last),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .decode_mode_restore (decode_mode_restore),
        .pending_writes      (pending_writes),
        .failures            (failures)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Stall the write channel at random
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one number after a random gap and hold it until the transfer
    task automatic send_number(input logic [3:0] pos, input logic [31:0] val);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            start_position <= 4'($urandom);
            value <= $urandom;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        start_position <= pos;
        value <= val;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        @(negedge clk);
    endtask

    // Wait until every write has come out, then load the decode-mode register
    task automatic load_restore_mode(input logic [7:0] mode);
        in_valid <= 1'b0;
        wait (pending_writes == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        decode_mode_restore <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        decode_mode_restore <= 8'($urandom);
    endtask

    // Send random numbers of every length, sign and start position
    task automatic run_random_numbers(input int count);
        logic [3:0]  pos;
        logic [31:0] val;
        int unsigned span;
        int          k;
        repeat (count)
        begin
            pos = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 8))
                                             : 4'($urandom_range(0, 15));
            k = $urandom_range(1, 9);
            span = 1;
            repeat (k) span = span * 10;
            case ($urandom_range(0, 3))
                0: val = $urandom;
                1: val = $urandom_range(0, span - 1);
                2: val = span - $urandom_range(0, 1);
                default:
                    case ($urandom_range(0, 3))
                        0: val = 32'd0;
                        1: val = 32'h8000_0000;
                        2: val = 32'h7FFF_FFFF;
                        default: val = 32'd1;
                    endcase
            endcase
            if ($urandom_range(0, 1) && val != 32'h8000_0000)
                val = 32'd0 - val;
            send_number(pos, val);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_position = 4'd0;
        value = 32'sd0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        decode_mode_restore = 8'd0;
        quiet_cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed numbers under the reset decode mode
        send_number(4'd8, 32'd0);
        send_number(4'd8, 32'd1);
        send_number(4'd8, -32'sd1);
        send_number(4'd8, 32'h7FFF_FFFF);
        send_number(4'd8, 32'h8000_0000);
        send_number(4'd15, 32'h8000_0000);
        send_number(4'd0, 32'd5);
        send_number(4'd0, -32'sd7);
        send_number(4'd1, -32'sd3);
        send_number(4'd1, 32'd42);
        send_number(4'd2, 32'd9);
        send_number(4'd3, 32'd10);
        send_number(4'd4, -32'sd10);
        send_number(4'd5, 32'd1234567890);
        send_number(4'd6, 32'd99999999);
        send_number(4'd7, -32'sd12345678);
        send_number(4'd8, -32'sd1234567);
        send_number(4'd9, 32'd100000000);
        send_number(4'd12, 32'd987654321);
        send_number(4'd15, 32'hFFFF_FFFF);

        // No idling, raw restore mode
        load_restore_mode(8'h00);
        run_random_numbers(PHASE_ITEMS);

        // Sender idles, code-B restore mode
        load_restore_mode(8'hFF);
        sender_idle_pct = 61;
        run_random_numbers(PHASE_ITEMS);

        // Receiver stalls, random restore mode
        load_restore_mode(8'($urandom));
        sender_idle_pct = 0;
        receiver_stall_pct = 61;
        run_random_numbers(PHASE_ITEMS);

        // Both sides idle
        load_restore_mode(8'($urandom));
        sender_idle_pct = 31;
        receiver_stall_pct = 31;
        run_random_numbers(PHASE_ITEMS);

        // Drain, then give the verdict
        in_valid <= 1'b0;
        wait (pending_writes == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sitdr_pkg.sv
rtl/sitdr_front.sv
rtl/sitdr_queue.sv
rtl/sitdr_back.sv
rtl/signed_int_to_digit_register_writes.sv
tb/display_write_monitor.sv
tb/signed_int_to_digit_register_writes_test.sv
